// ===== sv/bts_pkg.sv =====
// shared types and constants of the beveled tile shader
package bts_pkg;

	localparam int unsigned APB_AW = 3;

	// register index taken from paddr[2]
	localparam logic REG_IDX_BLOCK_SIZE = 1'b0;

	localparam logic [5:0] BSIZE_RESET = 6'd11;
	localparam logic [6:0] BEVEL_LIMIT = 7'd11;
	localparam logic [6:0] BEVEL_NARROW = 7'd2;
	localparam logic [6:0] BEVEL_WIDE = 7'd3;

	localparam logic [6:0] GLOSS_X0 = 7'd2;
	localparam logic [6:0] GLOSS_X1 = 7'd6;
	localparam logic [6:0] GLOSS_Y0 = 7'd2;
	localparam logic [6:0] GLOSS_Y1 = 7'd5;

	localparam logic signed [7:0] OFS_TOP = 8'sd18;
	localparam logic signed [7:0] OFS_LEFT = 8'sd14;
	localparam logic signed [7:0] OFS_BOTTOM = -8'sd18;
	localparam logic signed [7:0] OFS_RIGHT = -8'sd14;
	localparam logic signed [7:0] OFS_GLOSS = 8'sd24;

	localparam logic [9:0] GRAD_STEP = 10'd10;
	localparam int unsigned GRAD_STEPS = 9;

	// x*20/31 as (x*42300)>>16 and x*32/63 as (x*4162)>>13, exact over the ranges
	localparam logic [20:0] NORM_RB_MUL = 21'd42300;
	localparam logic [18:0] NORM_G_MUL = 19'd4162;

	localparam logic [7:0] CH5_MAX = 8'd31;
	localparam logic [7:0] CH6_MAX = 8'd63;

	typedef enum logic [2:0] {
		RGN_INNER,
		RGN_GLOSS,
		RGN_RIGHT,
		RGN_BOTTOM,
		RGN_LEFT,
		RGN_TOP
	} region_t;

	typedef struct packed {
		logic [8:0]  origin_x;
		logic [8:0]  origin_y;
		logic [5:0]  pixel_col;
		logic [5:0]  pixel_row;
		logic [15:0] base_color;
	} pix_t;

	typedef struct packed {
		logic [8:0]  screen_x;
		logic [8:0]  screen_y;
		logic [15:0] pixel_color;
		logic        drawn;
	} shade_t;

endpackage

// ===== sv/beveled_tile_shader.sv =====
// Beveled tile shader: one pixel transaction in, one shaded pixel out, three pipeline
// stages (region classify, normalize and gradient step compare, offset and clamp).
// A new transaction is taken every cycle unless pix_stall is high. Stall propagates
// back only through full stages, so bubbles are squeezed out. block_size is set over
// the apb port by the user only while the pipeline is empty; no check enforces it.
module beveled_tile_shader (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bts_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        pix_valid,
	output logic                        pix_stall,
	input  bts_pkg::pix_t               pix,
	output logic                        shade_valid,
	input  logic                        shade_stall,
	output bts_pkg::shade_t             shade
);
	import bts_pkg::*;

	function automatic logic [5:0] clamp_ch(input logic signed [7:0] v, input logic [7:0] hi);
		logic [5:0] res;
		if (v < 0) begin
			res = 6'd0;
		end else if (v > $signed(hi)) begin
			res = hi[5:0];
		end else begin
			res = v[5:0];
		end
		return res;
	endfunction

	logic [5:0] block_size;

	bts_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.block_size (block_size)
	);

	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	assign en3 = !v_s3 || !shade_stall;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign pix_stall = !en1;

	// stage 1: classify
	logic [6:0] sz, bev, col7, row7;
	logic       inside_c, inner_c, gloss_c;
	region_t    region_c;
	logic [5:0] inner_sz_c, irow_c;
	logic [9:0] i10_c;
	logic [6:0] inner7;

	always_comb begin
		sz = {1'b0, block_size};
		bev = (sz <= BEVEL_LIMIT) ? BEVEL_NARROW : BEVEL_WIDE;
		col7 = {1'b0, pix.pixel_col};
		row7 = {1'b0, pix.pixel_row};
		inside_c = (col7 < sz) && (row7 < sz);
		inner_c = (sz > (bev << 1)) && (col7 >= bev) && ((col7 + bev) < sz)
			&& (row7 >= bev) && ((row7 + bev) < sz);
		gloss_c = (col7 >= GLOSS_X0) && (col7 < GLOSS_X1)
			&& (row7 >= GLOSS_Y0) && (row7 < GLOSS_Y1);
		if (inner_c) begin
			region_c = RGN_INNER;
		end else if (gloss_c) begin
			region_c = RGN_GLOSS;
		end else if ((col7 + bev) >= sz) begin
			region_c = RGN_RIGHT;
		end else if ((row7 + bev) >= sz) begin
			region_c = RGN_BOTTOM;
		end else if (col7 < bev) begin
			region_c = RGN_LEFT;
		end else begin
			region_c = RGN_TOP;
		end
		inner7 = sz - (bev << 1);
		inner_sz_c = inner7[5:0];
		irow_c = 6'(row7 - bev);
		i10_c = 10'(irow_c) * GRAD_STEP;
	end

	logic [8:0]  sx_s1, sy_s1;
	logic        drawn_s1;
	region_t     region_s1;
	logic [5:0]  inner_s1;
	logic [9:0]  i10_s1;
	logic [15:0] base_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			sx_s1 <= pix.origin_x + 9'(pix.pixel_col);
			sy_s1 <= pix.origin_y + 9'(pix.pixel_row);
			drawn_s1 <= inside_c;
			region_s1 <= region_c;
			inner_s1 <= inner_sz_c;
			i10_s1 <= i10_c;
			base_s1 <= pix.base_color;
		end
	end

	// stage 2: normalize and gradient quotient
	logic [3:0]  q_c;
	logic [20:0] nr_mul, nb_mul;
	logic [18:0] ng_mul;

	always_comb begin
		logic [9:0] thr;
		q_c = 4'd0;
		for (int k = 1; k <= GRAD_STEPS; k++) begin
			thr = 10'(k) * {4'd0, inner_s1};
			q_c = q_c + 4'(i10_s1 >= thr);
		end
		nr_mul = 21'(base_s1[15:11]) * NORM_RB_MUL;
		ng_mul = 19'(base_s1[10:5]) * NORM_G_MUL;
		nb_mul = 21'(base_s1[4:0]) * NORM_RB_MUL;
	end

	logic [8:0]  sx_s2, sy_s2;
	logic        drawn_s2;
	region_t     region_s2;
	logic [3:0]  q_s2;
	logic [15:0] base_s2;
	logic [15:0] norm_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			sx_s2 <= sx_s1;
			sy_s2 <= sy_s1;
			drawn_s2 <= drawn_s1;
			region_s2 <= region_s1;
			q_s2 <= q_c;
			base_s2 <= base_s1;
			norm_s2 <= {nr_mul[20:16], ng_mul[18:13], nb_mul[20:16]};
		end
	end

	// stage 3: offset and clamp
	logic [15:0]       src_c;
	logic signed [7:0] ofs_c;
	logic [15:0]       color_c;
	logic [5:0]        cr, cg, cb;

	always_comb begin
		src_c = norm_s2;
		case (region_s2)
			RGN_INNER: begin
				src_c = base_s2;
				ofs_c = -$signed({4'd0, q_s2});
			end
			RGN_GLOSS:  ofs_c = OFS_GLOSS;
			RGN_RIGHT:  ofs_c = OFS_RIGHT;
			RGN_BOTTOM: ofs_c = OFS_BOTTOM;
			RGN_LEFT:   ofs_c = OFS_LEFT;
			RGN_TOP:    ofs_c = OFS_TOP;
			default:    ofs_c = OFS_TOP;
		endcase
		cr = clamp_ch($signed({3'd0, src_c[15:11]}) + ofs_c, CH5_MAX);
		cg = clamp_ch($signed({2'd0, src_c[10:5]}) + ofs_c, CH6_MAX);
		cb = clamp_ch($signed({3'd0, src_c[4:0]}) + ofs_c, CH5_MAX);
		color_c = drawn_s2 ? {cr[4:0], cg, cb[4:0]} : 16'd0;
	end

	shade_t out_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			out_s3.screen_x <= sx_s2;
			out_s3.screen_y <= sy_s2;
			out_s3.pixel_color <= color_c;
			out_s3.drawn <= drawn_s2;
		end
	end

	assign shade_valid = v_s3;
	assign shade = out_s3;

`ifndef ASSERT_OFF
	a_undrawn_black: assert property (@(posedge clk) disable iff (!arst_n)
		shade_valid && !shade.drawn |-> shade.pixel_color == 16'd0)
		else $error("undrawn pixel carries a color");

	a_quot_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> q_s2 <= 4'd9)
		else $error("gradient quotient out of range");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> v_s1 && v_s2 && v_s3 && shade_stall)
		else $error("input stalled with room in the pipeline");

	a_inner_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && region_s1 == RGN_INNER |-> inner_s1 != 6'd0)
		else $error("inner region with empty inner area");
`endif

endmodule

// ===== sv/bts_cfg.sv =====
// apb register file holding the tile size
module bts_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bts_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output logic [5:0]                  block_size
);
	import bts_pkg::*;

	logic [5:0] block_size_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && (paddr[2] == REG_IDX_BLOCK_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q <= BSIZE_RESET;
		end else if (wr_en) begin
			block_size_q <= pwdata[5:0];
		end
	end

	always_comb begin
		if (paddr[2] == REG_IDX_BLOCK_SIZE) begin
			prdata = {26'd0, block_size_q};
		end else begin
			prdata = 32'd0;
		end
	end

	assign block_size = block_size_q;

endmodule
